/* rtl/ms_pkg.sv */
// Shared types for the merge sorter: the sequencer state encoding.
`default_nettype none

package ms_pkg;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_MERGE,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

/* rtl/merge_sorter.sv */
// Merge sorter top level: load sequencer, bottom-up merge passes and sorted output.
//
// Usage: signed values arrive on the s_ channel, one per transaction, with
// s_tlast on the final value of a list. Up to MAX_ITEMS values are kept; values
// that arrive with the store full are discarded and remembered. The transaction
// carrying s_tlast starts the sort, and s_tready stays low until the whole
// sorted list has been handed to the output register.
// The m_ channel then delivers the list in ascending order (equal values: the
// later run's element first). m_tlast marks the final element, and m_tuser is
// high on that element only if values were discarded during loading.
// Sequence for a list of n values: the values load at one per cycle, then
// ceil(log2 n) merge passes follow, each merging one element per cycle (bounded by
// the single write port of the destination RAM) and each preceded by a settle
// state, and a last settle state comes before the values are emitted one per
// cycle while the receiver does not stall.
// The two RAMs are used in ping-pong fashion, so no copy-back pass is needed.
// A stalled receiver holds the output register; the sorter waits on it and
// loses nothing. A new list may start loading while the last result waits.
// Reset (rst, synchronous) empties the list and the output register; RAM
// contents are not cleared and need no clearing.
`default_nettype none

module merge_sorter #(
  parameter int MAX_ITEMS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [((DATA_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // value
  input  wire logic                                 s_tlast,  // last
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic      [((DATA_WIDTH + 7) / 8) * 8-1:0] m_tdata,  // sorted_value
  output logic                                      m_tlast,  // end_of_list
  output logic                                      m_tuser   // dropped
);

  import ms_pkg::*;

  localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int AW      = $clog2(MAX_ITEMS);
  localparam int CW      = $clog2(MAX_ITEMS + 1);
  localparam int WW      = CW + 1;
  localparam int SW      = CW + 2;

  state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic          overflow, overflow_next;
  logic [WW-1:0] width, width_next;
  logic          src, src_next;
  logic [CW-1:0] a, a_next;
  logic [CW-1:0] b, b_next;
  logic [CW-1:0] mid, mid_next;
  logic [CW-1:0] hi, hi_next;
  logic [CW-1:0] k, k_next;

  logic                  out_valid, out_valid_next;
  logic [DATA_WIDTH-1:0] out_data, out_data_next;
  logic                  out_last, out_last_next;
  logic                  out_dropped, out_dropped_next;

  logic                  e_we, m_we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] e_rd_a, e_rd_b, m_rd_a, m_rd_b;
  logic [DATA_WIDTH-1:0] head_a, head_b;
  logic                  take_a;
  logic                  emit_last;

  logic [SW-1:0] w_s, n_s, hi_s, seg_mid, seg_hi, first_hi;

  ms_ram #(.DEPTH(MAX_ITEMS), .WIDTH(DATA_WIDTH)) u_element_ram (
    .clk     (clk),
    .we      (e_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (a_next[AW-1:0]),
    .raddr_b (b_next[AW-1:0]),
    .rdata_a (e_rd_a),
    .rdata_b (e_rd_b)
  );

  ms_ram #(.DEPTH(MAX_ITEMS), .WIDTH(DATA_WIDTH)) u_merge_ram (
    .clk     (clk),
    .we      (m_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (a_next[AW-1:0]),
    .raddr_b (b_next[AW-1:0]),
    .rdata_a (m_rd_a),
    .rdata_b (m_rd_b)
  );

  // Reads always follow the next pointer values, so the registered words match
  // the current pointers.
  assign head_a = src ? m_rd_a : e_rd_a;
  assign head_b = src ? m_rd_b : e_rd_b;

  assign w_s      = SW'(width);
  assign n_s      = SW'(count);
  assign hi_s     = SW'(hi);
  assign first_hi = ((w_s << 1) < n_s) ? (w_s << 1) : n_s;
  assign seg_mid  = ((hi_s + w_s) < n_s) ? (hi_s + w_s) : n_s;
  assign seg_hi   = ((hi_s + (w_s << 1)) < n_s) ? (hi_s + (w_s << 1)) : n_s;

  assign take_a    = (a < mid) && ((b >= hi) || ($signed(head_a) < $signed(head_b)));
  assign emit_last = ((a + CW'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      overflow  <= 1'b0;
      width     <= '0;
      src       <= 1'b0;
      a         <= '0;
      b         <= '0;
      mid       <= '0;
      hi        <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      overflow  <= overflow_next;
      width     <= width_next;
      src       <= src_next;
      a         <= a_next;
      b         <= b_next;
      mid       <= mid_next;
      hi        <= hi_next;
      k         <= k_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data    <= out_data_next;
    out_last    <= out_last_next;
    out_dropped <= out_dropped_next;
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    overflow_next    = overflow;
    width_next       = width;
    src_next         = src;
    a_next           = a;
    b_next           = b;
    mid_next         = mid;
    hi_next          = hi;
    k_next           = k;
    out_valid_next   = out_valid && !m_tready;
    out_data_next    = out_data;
    out_last_next    = out_last;
    out_dropped_next = out_dropped;
    s_tready         = 1'b0;
    e_we             = 1'b0;
    m_we             = 1'b0;
    waddr            = k[AW-1:0];
    wdata            = take_a ? head_a : head_b;

    case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (count < CW'(MAX_ITEMS)) begin
            e_we       = 1'b1;
            waddr      = count[AW-1:0];
            wdata      = s_tdata[DATA_WIDTH-1:0];
            count_next = count + CW'(1);
          end else begin
            overflow_next = 1'b1;
          end
          if (s_tlast) begin
            width_next = WW'(1);
            src_next   = 1'b0;
            state_next = ST_SETTLE;
          end
        end
      end

      // An idle state so that reads never meet a write that has just landed.
      ST_SETTLE: begin
        if (w_s >= n_s) begin
          a_next     = '0;
          state_next = ST_EMIT;
        end else begin
          mid_next   = CW'(width);
          hi_next    = CW'(first_hi);
          a_next     = '0;
          b_next     = CW'(width);
          k_next     = '0;
          state_next = ST_MERGE;
        end
      end

      ST_MERGE: begin
        m_we   = !src;
        e_we   = src;
        k_next = k + CW'(1);
        if (take_a) begin
          a_next = a + CW'(1);
        end else begin
          b_next = b + CW'(1);
        end
        if ((k + CW'(1)) == hi) begin
          if (hi == count) begin
            src_next   = !src;
            width_next = width << 1;
            state_next = ST_SETTLE;
          end else begin
            a_next   = hi;
            mid_next = CW'(seg_mid);
            b_next   = CW'(seg_mid);
            hi_next  = CW'(seg_hi);
            k_next   = hi;
          end
        end
      end

      ST_EMIT: begin
        if (!out_valid || m_tready) begin
          out_valid_next   = 1'b1;
          out_data_next    = head_a;
          out_last_next    = emit_last;
          out_dropped_next = emit_last && overflow;
          a_next           = a + CW'(1);
          if (emit_last) begin
            count_next    = '0;
            overflow_next = 1'b0;
            state_next    = ST_LOAD;
          end
        end
      end

      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_W'(out_data);
  assign m_tlast  = out_last;
  assign m_tuser  = out_dropped;

  // The fill count never passes the capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_ITEMS))
    else $error("fill count beyond capacity");

  // Values are only discarded once the store is full.
  assert property (@(posedge clk) disable iff (rst) overflow |-> (count == CW'(MAX_ITEMS)))
    else $error("overflow flagged while store not full");

  // The write pointer always equals the segment start plus the elements consumed from both runs.
  assert property (@(posedge clk) disable iff (rst)
      (state == ST_MERGE) |-> ((SW'(k) + SW'(mid)) == (SW'(a) + SW'(b))))
    else $error("merge pointers out of step");

  // Run pointers stay inside their runs while merging.
  assert property (@(posedge clk) disable iff (rst)
      (state == ST_MERGE) |-> ((a <= mid) && (b <= hi) && (hi <= count)))
    else $error("merge pointer out of range");

  // Once the value carrying s_tlast is taken, s_tready drops as the sort begins.
  assert property (@(posedge clk) disable iff (rst)
      (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input accepted during sort");

endmodule

`default_nettype wire

/* rtl/ms_ram.sv */
// Simple RAM with one write port and two registered read ports.
`default_nettype none

module ms_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read before write: a read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* tb/sv/merge_sorter_test.sv */
// Self-checking testbench for the merge sorter: directed lists, random lists, random stalls.
`default_nettype none

module merge_sorter_test;

  localparam int WIDTH        = 32;
  localparam int CAPACITY     = 16;
  localparam int IDLE_PCT     = 12;
  localparam int RANDOM_ITEMS = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 120;
  localparam int REPORT_MAX   = 10;

  typedef logic signed [WIDTH-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  eol;
    logic  dropped;
  } sorted_t;

  typedef struct {
    word_t   value;
    bit      last;
    bit      typed;
    sorted_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  word_t      s_tdata;  // value
  logic       s_tlast;  // last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  word_t      m_tdata;  // sorted_value
  logic       m_tlast;  // end_of_list
  logic       m_tuser;  // dropped

  // Predictor state: the list being loaded and whether anything was thrown away.
  word_t      held_values[$];
  bit         lost_value;
  sorted_t    sorted_due[$];
  stim_row_t  plan[$];

  bit         calm;
  bit         timed_out;
  int         quiet_cycles;
  int         errors;
  int         results_seen;
  int         items_sent;
  int         lists_sorted;
  int         overflow_lists;

  merge_sorter #(
    .MAX_ITEMS (CAPACITY),
    .DATA_WIDTH(WIDTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  always #1 clk = ~clk;

  // Stores the value (or notes it as lost when full), and on a last item sorts the held list and lists the results due.
  task automatic predict_load(input word_t v, input bit l, output sorted_t produced[$]);
    word_t ordered[$];
    word_t key;
    int    n;
    int    j;
    produced.delete();
    if (held_values.size() < CAPACITY) held_values.push_back(v);
    else lost_value = 1'b1;
    if (l) begin
      ordered = held_values;
      n = ordered.size();
      // Equal values are bit-identical, so the tie rule cannot change what comes out.
      for (int i = 1; i < n; i++) begin
        key = ordered[i];
        j = i;
        while (j > 0 && ordered[j-1] > key) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = key;
      end
      for (int i = 0; i < n; i++) begin
        produced.push_back(sorted_t'{ordered[i], i == n - 1, (i == n - 1) && lost_value});
      end
      lists_sorted++;
      if (lost_value) overflow_lists++;
      held_values.delete();
      lost_value = 1'b0;
    end
  endtask

  task automatic add_row(input word_t v, input bit l, input bit typed, input sorted_t want);
    plan.push_back(stim_row_t'{v, l, typed, want});
  endtask

  task automatic send_item(input word_t v, input bit l, input bit typed, input sorted_t want);
    sorted_t produced[$];
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predict_load(v, l, produced);
    if (typed) sorted_due.push_back(want);
    else foreach (produced[i]) sorted_due.push_back(produced[i]);
  endtask

  function automatic word_t pick_value(input int flavor);
    word_t corners[5];
    corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
    case (flavor)
      1: begin
        return word_t'($urandom_range(8)) - 4;
      end
      2: begin
        return corners[$urandom_range(4)];
      end
      default: begin
        return word_t'($urandom);
      end
    endcase
  endfunction

  // Output side: random backpressure, and a check of every transaction that completes.
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    sorted_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (sorted_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result: value %0d eol %b dropped %b", m_tdata, m_tlast, m_tuser);
      end else begin
        want = sorted_due.pop_front();
        if (m_tdata !== want.value || m_tlast !== want.eol || m_tuser !== want.dropped) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("mismatch: expected value %0d eol %b dropped %b, got %0d %b %b",
                     want.value, want.eol, want.dropped, m_tdata, m_tlast, m_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    int   len;
    int   flavor;
    int   list_index;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    rst          = 1'b1;
    calm         = 1'b0;
    timed_out    = 1'b0;
    lost_value   = 1'b0;

    // Single-value lists at both extremes, a pair, a list with repeats, then a full
    // store followed by one more value that is marked last and gets dropped.
    add_row(32'h7FFF_FFFF, 1'b1, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0});
    add_row(32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 1'b0});
    add_row(32'sd5, 1'b0, 1'b0, '0);
    add_row(-32'sd5, 1'b1, 1'b0, '0);
    add_row(32'sd3, 1'b0, 1'b0, '0);
    add_row(32'sd3, 1'b0, 1'b0, '0);
    add_row(-32'sd1, 1'b0, 1'b0, '0);
    add_row(32'sd3, 1'b1, 1'b0, '0);
    for (int k = 0; k < CAPACITY; k++) begin
      add_row(32'h7FFF_FFF0 - k * 32'h1111_1111, 1'b0, 1'b0, '0);
    end
    add_row(32'h8000_0000, 1'b1, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    fork
      begin
        foreach (plan[i]) send_item(plan[i].value, plan[i].last, plan[i].typed, plan[i].want);
        list_index = 0;
        while (items_sent < plan.size() + RANDOM_ITEMS) begin
          // A run of lists in the middle goes through without any stalls.
          calm   = (list_index >= 8 && list_index < 14);
          len    = ($urandom_range(7) == 0) ? $urandom_range(CAPACITY + 4, CAPACITY + 1)
                                            : $urandom_range(CAPACITY, 1);
          flavor = $urandom_range(3);
          for (int k = 0; k < len; k++) send_item(pick_value(flavor), k == len - 1, 1'b0, '0);
          list_index++;
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        while (sorted_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      begin
        wait (quiet_cycles >= STALL_LIMIT);
        timed_out = 1'b1;
      end
    join_any
    disable fork;

    if (timed_out) $display("no transaction for %0d cycles, stopping", STALL_LIMIT);
    if (sorted_due.size() != 0) begin
      $display("%0d expected results never arrived", sorted_due.size());
    end
    $display("Loaded %0d values into %0d lists, %0d of them overfull.",
             items_sent, lists_sorted, overflow_lists);
    $display("Checked %0d sorted results, %0d mismatches.", results_seen, errors);
    if (!timed_out && errors == 0 && sorted_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
